// ===== rtl/core/rexb_pkg.sv =====
// shared opcodes and stage types for the execute and branch unit
`default_nettype none

package rexb_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned HALF_W = DATA_W / 2;
  localparam int unsigned OP_W   = 8;
  localparam int unsigned SHAMT_W = 5;

  localparam logic [OP_W-1:0] OP_ADD  = 8'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 8'd1;
  localparam logic [OP_W-1:0] OP_AND  = 8'd2;
  localparam logic [OP_W-1:0] OP_OR   = 8'd3;
  localparam logic [OP_W-1:0] OP_XOR  = 8'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 8'd5;
  localparam logic [OP_W-1:0] OP_SLL  = 8'd6;
  localparam logic [OP_W-1:0] OP_SRA  = 8'd7;
  localparam logic [OP_W-1:0] OP_SRL  = 8'd8;
  localparam logic [OP_W-1:0] OP_BEQ  = 8'd9;
  localparam logic [OP_W-1:0] OP_BNE  = 8'd10;
  localparam logic [OP_W-1:0] OP_BLT  = 8'd11;
  localparam logic [OP_W-1:0] OP_BGT  = 8'd12;
  localparam logic [OP_W-1:0] OP_BLE  = 8'd13;
  localparam logic [OP_W-1:0] OP_BGE  = 8'd14;
  localparam logic [OP_W-1:0] OP_JAL  = 8'd15;
  localparam logic [OP_W-1:0] OP_HALT = 8'd20;

  // register index that selects the immediate instead of a register value
  localparam logic [3:0] IMM_SEL_IDX = 4'd1;
  localparam logic [3:0] ZERO_IDX    = 4'd0;

  // what the execute stage hands to the writeback stage
  typedef struct packed {
    logic [DATA_W-1:0] res;     // every result except the product
    logic [DATA_W-1:0] pp_lo;   // low half of a times low half of b
    logic [HALF_W-1:0] pp_mid;  // low bits of the two cross products summed
    logic              taken;
  } exe_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/risc_execute_and_branch_unit.sv =====
// execute and branch resolution unit, three-stage pipeline
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall  | decoded instruction, operands, pc
//  out_    | output    | out_valid / out_stall| alu result, next pc, write flags
//
// a word accepted by the operand stage moves through the execute stage to the
// output register, which raises out_valid; one word per cycle sustained while
// out_stall is low. stages: operand select, execute (alu, compare, 16-bit
// partial products), product sum with result select and next-pc mux. each
// stage holds a valid bit and moves on when the stage after it is empty or
// moving. out_stall holds the output register; bubbles collapse so earlier
// stages keep filling. rst_n clears the valid bits only.
`default_nettype none

module risc_execute_and_branch_unit #(
  parameter int unsigned IMM_BITS = 12,
  parameter int unsigned PC_BITS  = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rexb_pkg::OP_W-1:0]     in_req_type,
  input  wire logic [3:0]                    in_dest_index,
  input  wire logic [3:0]                    in_src1_index,
  input  wire logic [3:0]                    in_src2_index,
  input  wire logic [IMM_BITS-1:0]           in_imm_field,
  input  wire logic signed [rexb_pkg::DATA_W-1:0] in_dest_value,
  input  wire logic signed [rexb_pkg::DATA_W-1:0] in_src1_value,
  input  wire logic signed [rexb_pkg::DATA_W-1:0] in_src2_value,
  input  wire logic [PC_BITS-1:0]            in_cur_pc,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [rexb_pkg::DATA_W-1:0] out_alu_result,
  output logic [PC_BITS-1:0]                 out_next_pc,
  output logic                               out_branch_taken,
  output logic                               out_link_write,
  output logic [PC_BITS-1:0]                 out_link_value,
  output logic                               out_reg_write,
  output logic                               out_halt_seen
);

  localparam int unsigned DW = rexb_pkg::DATA_W;

  // stage handshake
  logic adv1, adv2, adv3;
  logic v1_r, v2_r, v3_r;

  // stage 1: operands
  logic [rexb_pkg::OP_W-1:0] op1_r;
  logic                      rd_ok1_r;
  logic [DW-1:0]             a1_r, b1_r;
  logic [PC_BITS-1:0]        tgt1_r, inc1_r;

  logic [DW-1:0]             imm_ext;
  logic [DW-1:0]             a_nxt, b_nxt;
  logic [PC_BITS-1:0]        tgt_nxt, inc_nxt;

  // stage 2: execute
  logic [rexb_pkg::OP_W-1:0] op2_r;
  logic                      rd_ok2_r;
  logic [PC_BITS-1:0]        tgt2_r, inc2_r;
  rexb_pkg::exe_out_t        exe;
  rexb_pkg::exe_out_t        exe2_r;

  // stage 3: output register
  logic [DW-1:0]             res3_r, res_nxt;
  logic [PC_BITS-1:0]        npc3_r, inc3_r;
  logic                      taken3_r, link3_r, wr3_r, halt3_r;

  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  assign imm_ext = {{(DW-IMM_BITS){in_imm_field[IMM_BITS-1]}}, in_imm_field};
  assign a_nxt = (in_src1_index == rexb_pkg::IMM_SEL_IDX) ? imm_ext : $unsigned(in_src1_value);
  assign b_nxt = (in_src2_index == rexb_pkg::IMM_SEL_IDX) ? imm_ext : $unsigned(in_src2_value);
  assign tgt_nxt = (in_dest_index == rexb_pkg::IMM_SEL_IDX) ? imm_ext[PC_BITS-1:0]
                                                           : in_dest_value[PC_BITS-1:0];
  assign inc_nxt = in_cur_pc + PC_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      op1_r    <= in_req_type;
      rd_ok1_r <= (in_dest_index != rexb_pkg::ZERO_IDX) &&
                  (in_dest_index != rexb_pkg::IMM_SEL_IDX);
      a1_r     <= a_nxt;
      b1_r     <= b_nxt;
      tgt1_r   <= tgt_nxt;
      inc1_r   <= inc_nxt;
    end
  end

  rexb_alu u_alu (
    .op  (op1_r),
    .a   (a1_r),
    .b   (b1_r),
    .exe (exe)
  );

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      op2_r    <= op1_r;
      rd_ok2_r <= rd_ok1_r;
      tgt2_r   <= tgt1_r;
      inc2_r   <= inc1_r;
      exe2_r   <= exe;
    end
  end

  // low word of the product: cross terms only matter in the upper half
  assign res_nxt = (op2_r == rexb_pkg::OP_MUL)
                   ? exe2_r.pp_lo + {exe2_r.pp_mid, {rexb_pkg::HALF_W{1'b0}}}
                   : exe2_r.res;

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      res3_r   <= res_nxt;
      npc3_r   <= exe2_r.taken ? tgt2_r : inc2_r;
      inc3_r   <= inc2_r;
      taken3_r <= exe2_r.taken;
      link3_r  <= (op2_r == rexb_pkg::OP_JAL);
      wr3_r    <= (op2_r <= rexb_pkg::OP_SRL) && rd_ok2_r;
      halt3_r  <= (op2_r == rexb_pkg::OP_HALT);
    end
  end

  assign out_valid        = v3_r;
  assign out_alu_result   = $signed(res3_r);
  assign out_next_pc      = npc3_r;
  assign out_branch_taken = taken3_r;
  assign out_link_write   = link3_r;
  assign out_link_value   = inc3_r;
  assign out_reg_write    = wr3_r;
  assign out_halt_seen    = halt3_r;

endmodule

`default_nettype wire

// ===== rtl/core/rexb_alu.sv =====
// execute stage: adder, logic, shifter, partial products and branch compare
`default_nettype none

module rexb_alu (
  input  wire logic [rexb_pkg::OP_W-1:0]   op,
  input  wire logic [rexb_pkg::DATA_W-1:0] a,
  input  wire logic [rexb_pkg::DATA_W-1:0] b,
  output rexb_pkg::exe_out_t               exe
);

  localparam int unsigned HW = rexb_pkg::HALF_W;

  logic [rexb_pkg::SHAMT_W-1:0] shamt;
  logic                         eq;
  logic                         lt;
  logic                         gt;
  logic [HW-1:0]                a_lo, a_hi, b_lo, b_hi;

  assign shamt = b[rexb_pkg::SHAMT_W-1:0];
  assign eq = (a == b);
  assign lt = ($signed(a) < $signed(b));
  assign gt = ($signed(b) < $signed(a));

  assign a_lo = a[HW-1:0];
  assign a_hi = a[rexb_pkg::DATA_W-1:HW];
  assign b_lo = b[HW-1:0];
  assign b_hi = b[rexb_pkg::DATA_W-1:HW];

  always_comb begin
    // 16-bit partial products, summed into the low word in the next stage
    exe.pp_lo  = a_lo * b_lo;
    exe.pp_mid = a_hi * b_lo + a_lo * b_hi;

    unique case (op)
      rexb_pkg::OP_SUB: exe.res = a - b;
      rexb_pkg::OP_AND: exe.res = a & b;
      rexb_pkg::OP_OR:  exe.res = a | b;
      rexb_pkg::OP_XOR: exe.res = a ^ b;
      rexb_pkg::OP_SLL: exe.res = a << shamt;
      rexb_pkg::OP_SRA: exe.res = $unsigned($signed(a) >>> shamt);
      rexb_pkg::OP_SRL: exe.res = a >> shamt;
      default:          exe.res = a + b;
    endcase

    unique case (op)
      rexb_pkg::OP_BEQ: exe.taken = eq;
      rexb_pkg::OP_BNE: exe.taken = !eq;
      rexb_pkg::OP_BLT: exe.taken = lt;
      rexb_pkg::OP_BGT: exe.taken = gt;
      rexb_pkg::OP_BLE: exe.taken = !gt;
      rexb_pkg::OP_BGE: exe.taken = !lt;
      rexb_pkg::OP_JAL: exe.taken = 1'b1;
      default:          exe.taken = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
